// File: src/http_response_header_parser_assert.svh
// Assertion macros for the HTTP response header parser
`ifndef HTTP_RESPONSE_HEADER_PARSER_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_PARSER_ASSERT_SVH
`ifndef SYNTH
`define HRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HRP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HRP_ASSERT(label, prop, msg)
`define HRP_ASSERT_RST(label, prop, msg)
`endif
`endif

// File: src/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// Types and constants shared by the HTTP response header parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int unsigned HeaderMax = 2048;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [2:0] OUT_OK = 3'd0;
  localparam logic [2:0] OUT_PROTO = 3'd1;
  localparam logic [2:0] OUT_CHUNKED = 3'd2;
  localparam logic [2:0] OUT_HDR_OVF = 3'd3;
  localparam logic [2:0] OUT_TIMEOUT = 3'd4;
  localparam logic [2:0] OUT_BODY_OVF = 3'd5;

  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [3:0] ST_DONE = 4'd11;
  localparam logic [3:0] ST_FAIL = 4'd12;
  localparam logic [3:0] VS_IDLE = 4'd15;

  localparam logic [2:0] REG_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_CAPACITY = 3'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        body_valid;
    logic        body_keep;
    logic [7:0]  body_byte;
    logic        headers_done;
    logic [15:0] status_value;
    logic        length_known;
    logic [31:0] declared_len;
    logic [31:0] body_total;
    logic        finished;
    logic [2:0]  outcome;
  } out_item_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C
      || b == 8'h0D;
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0: c = "t";  5'd1: c = "r";  5'd2: c = "a";  5'd3: c = "n";
      5'd4: c = "s";  5'd5: c = "f";  5'd6: c = "e";  5'd7: c = "r";
      5'd8: c = "-";  5'd9: c = "e";  5'd10: c = "n"; 5'd11: c = "c";
      5'd12: c = "o"; 5'd13: c = "d"; 5'd14: c = "i"; 5'd15: c = "n";
      5'd16: c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cl_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0: c = "c";  5'd1: c = "o";  5'd2: c = "n";  5'd3: c = "t";
      5'd4: c = "e";  5'd5: c = "n";  5'd6: c = "t";  5'd7: c = "-";
      5'd8: c = "l";  5'd9: c = "e";  5'd10: c = "n"; 5'd11: c = "g";
      5'd12: c = "t"; 5'd13: c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ck_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = "c"; 4'd1: c = "h"; 4'd2: c = "u"; 4'd3: c = "n";
      4'd4: c = "k"; 4'd5: c = "e"; 4'd6: c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] http_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = "H"; 4'd1: c = "T"; 4'd2: c = "T"; 4'd3: c = "P";
      4'd4: c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: src/http_response_header_parser.sv
// ----------------------------------------------------------------------------
// http_response_header_parser
// Parses an HTTP response header stream and frames the body bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The in channel (in_valid/in_ready/in_item) carries one event per item:
//   a received byte, a connection close, a millisecond tick or a restart.
//   Every accepted item gives exactly one result item on the out channel
//   (out_valid/out_ready/out_item) with the body framing and status fields.
//   The item's effect is computed in the accepting cycle and registered
//   into the output register.
//   Throughput is one item per cycle while results are taken; the single
//   output register is the only stage, so in_ready follows the output
//   register being empty or being taken in the same cycle.
//   When the receiver stalls, the result holds and input is refused until
//   the result is taken; no item is lost.
//   Reset clears the parse state, loads timeout 15000 ms and capacity 0.
//   Registers sit on the APB port: timeout at 0x0, body capacity at 0x4.
//   Write them only while the block is idle.
// ----------------------------------------------------------------------------
`include "http_response_header_parser_assert.svh"

module http_response_header_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hrp_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output hrp_pkg::out_item_t  out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [31:0] resp_timeout;
  logic [31:0] capacity;

  logic [1:0]  phase;
  logic [10:0] hdr_bytes;
  logic [31:0] tail_window;
  logic [3:0]  status_step;
  logic [16:0] status_accum;
  logic [4:0]  line_pos;
  logic [1:0]  cands;
  logic [3:0]  value_step;
  logic [1:0]  seen;
  logic [31:0] length_accum;
  logic        length_valid;
  logic [32:0] body_counter;
  logic [31:0] elapsed_ms;
  logic [2:0]  end_code;
  logic        past_status;
  logic        search_stopped;
  logic        te_chunked;
  logic        cl_ok;
  logic        status_neg;
  logic        headers_seen;

  logic [1:0]  phase_next;
  logic [10:0] hdr_bytes_next;
  logic [31:0] tail_window_next;
  logic [3:0]  status_step_next;
  logic [16:0] status_accum_next;
  logic [4:0]  line_pos_next;
  logic [1:0]  cands_next;
  logic [3:0]  value_step_next;
  logic [1:0]  seen_next;
  logic [31:0] length_accum_next;
  logic        length_valid_next;
  logic [32:0] body_counter_next;
  logic [31:0] elapsed_ms_next;
  logic [2:0]  end_code_next;
  logic        past_status_next;
  logic        search_stopped_next;
  logic        te_chunked_next;
  logic        cl_ok_next;
  logic        status_neg_next;
  logic        headers_seen_next;

  hrp_pkg::out_item_t result;
  logic in_fire;
  logic cfg_write;

  assign in_ready = !out_valid || out_ready;
  assign in_fire = in_valid && in_ready;
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr)
      {hrp_pkg::REG_TIMEOUT[0], 2'b00}: prdata = resp_timeout;
      {hrp_pkg::REG_CAPACITY[0], 2'b00}: prdata = capacity;
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_timeout <= 32'd15000;
      capacity <= 32'd0;
    end else if (cfg_write && paddr[1:0] == 2'b00) begin
      if (paddr[2] == hrp_pkg::REG_TIMEOUT[0]) resp_timeout <= pwdata;
      else capacity <= pwdata;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  lb;
    logic [7:0]  prev;
    logic        crlf;
    logic        bv;
    logic        keep;
    logic        fin;
    logic [2:0]  fcode;
    logic [20:0] acc_mul;
    logic [35:0] len_mul;
    logic [3:0]  d;
    logic        code_ok;
    logic        end_close;

    b = in_item.data_byte;
    lb = hrp_pkg::to_lower(b);
    prev = tail_window[7:0];
    crlf = prev == 8'h0D && b == 8'h0A;
    d = b[3:0] - 4'd0;
    bv = 1'b0;
    keep = 1'b0;
    fin = 1'b0;
    fcode = hrp_pkg::OUT_OK;
    acc_mul = '0;
    len_mul = '0;
    end_close = 1'b0;

    phase_next = phase;
    hdr_bytes_next = hdr_bytes;
    tail_window_next = tail_window;
    status_step_next = status_step;
    status_accum_next = status_accum;
    line_pos_next = line_pos;
    cands_next = cands;
    value_step_next = value_step;
    seen_next = seen;
    length_accum_next = length_accum;
    length_valid_next = length_valid;
    body_counter_next = body_counter;
    elapsed_ms_next = elapsed_ms;
    end_code_next = end_code;
    past_status_next = past_status;
    search_stopped_next = search_stopped;
    te_chunked_next = te_chunked;
    cl_ok_next = cl_ok;
    status_neg_next = status_neg;
    headers_seen_next = headers_seen;

    if (in_item.opcode == hrp_pkg::OP_RESTART) begin
      phase_next = hrp_pkg::PH_HEAD;
      hdr_bytes_next = '0;
      tail_window_next = '0;
      status_step_next = '0;
      status_accum_next = '0;
      line_pos_next = '0;
      cands_next = 2'b11;
      value_step_next = '0;
      seen_next = '0;
      length_accum_next = '0;
      length_valid_next = 1'b0;
      body_counter_next = '0;
      elapsed_ms_next = '0;
      end_code_next = '0;
      past_status_next = 1'b0;
      search_stopped_next = 1'b0;
      te_chunked_next = 1'b0;
      cl_ok_next = 1'b0;
      status_neg_next = 1'b0;
      headers_seen_next = 1'b0;
    end else if (phase != hrp_pkg::PH_DONE) begin
      if (in_item.opcode == hrp_pkg::OP_TICK) begin
        if (elapsed_ms != 32'hFFFF_FFFF) elapsed_ms_next = elapsed_ms + 32'd1;
        if (elapsed_ms_next >= resp_timeout) begin
          fin = 1'b1;
          fcode = hrp_pkg::OUT_TIMEOUT;
        end
      end else if (elapsed_ms >= resp_timeout) begin
        fin = 1'b1;
        fcode = hrp_pkg::OUT_TIMEOUT;
      end else if (in_item.opcode == hrp_pkg::OP_CLOSE) begin
        if (phase == hrp_pkg::PH_HEAD) begin
          fin = 1'b1;
          fcode = hrp_pkg::OUT_PROTO;
        end else begin
          end_close = 1'b1;
        end
      end else if (phase == hrp_pkg::PH_HEAD) begin
        if ({1'b0, hdr_bytes} + 12'd1 >= 12'(hrp_pkg::HeaderMax)) begin
          fin = 1'b1;
          fcode = hrp_pkg::OUT_HDR_OVF;
        end else begin
          hdr_bytes_next = hdr_bytes + 11'd1;
          tail_window_next = {tail_window[23:0], b};

          // status line
          status_step_next = hrp_pkg::ST_FAIL;
          acc_mul = {4'd0, status_accum} * 21'd10 + {17'd0, d};
          if (status_step <= 4'd4) begin
            if (b == hrp_pkg::http_char(status_step)) status_step_next = status_step + 4'd1;
          end else if (status_step == 4'd5 || status_step == 4'd7) begin
            if (hrp_pkg::is_ws(b)) status_step_next = status_step;
            else if (b == "+" || b == "-")
              status_step_next = (status_step == 4'd5) ? 4'd13 : 4'd14;
            else if (hrp_pkg::is_dig(b)) status_step_next = status_step + 4'd1;
          end else if (status_step == 4'd13 || status_step == 4'd14) begin
            if (hrp_pkg::is_dig(b)) status_step_next = (status_step == 4'd13) ? 4'd6 : 4'd8;
          end else if (status_step == 4'd6) begin
            if (hrp_pkg::is_dig(b)) status_step_next = 4'd6;
            else if (b == ".") status_step_next = 4'd7;
          end else if (status_step == 4'd8 || status_step == 4'd9) begin
            if (status_step == 4'd8 && hrp_pkg::is_dig(b)) status_step_next = 4'd8;
            else if (hrp_pkg::is_ws(b)) status_step_next = 4'd9;
            else if (b == "+" || b == "-") begin
              status_neg_next = b == "-";
              status_step_next = 4'd15;
            end else if (status_step == 4'd9 && hrp_pkg::is_dig(b)) begin
              status_step_next = 4'd10;
              if (status_neg) begin
                if (d != 4'd0) status_accum_next = 17'h10000;
              end else begin
                status_accum_next = acc_mul > 21'h10000 ? 17'h10000 : acc_mul[16:0];
              end
            end
          end else if (status_step == 4'd15 || status_step == 4'd10) begin
            if (hrp_pkg::is_dig(b)) begin
              status_step_next = 4'd10;
              if (status_neg) begin
                if (d != 4'd0) status_accum_next = 17'h10000;
              end else begin
                status_accum_next = acc_mul > 21'h10000 ? 17'h10000 : acc_mul[16:0];
              end
            end else if (status_step == 4'd10) begin
              status_step_next = hrp_pkg::ST_DONE;
            end
          end else begin
            status_step_next = status_step;
          end

          // header lines
          if (!past_status) begin
            if (crlf) begin
              past_status_next = 1'b1;
              line_pos_next = '0;
              cands_next = 2'b11;
              value_step_next = '0;
            end
          end else begin
            if (line_pos == 5'd0 && b == 8'h0D) search_stopped_next = 1'b1;
            if (!search_stopped_next) begin
              // transfer-encoding
              if (cands[0]) begin
                if (line_pos < 5'd17) begin
                  if (lb != hrp_pkg::te_char(line_pos)) cands_next[0] = 1'b0;
                end else if (line_pos == 5'd17) begin
                  if (b == ":" && !seen[0]) begin
                    seen_next[0] = 1'b1;
                    value_step_next = '0;
                  end else begin
                    cands_next[0] = 1'b0;
                  end
                end else if (value_step != hrp_pkg::VS_IDLE
                             && !(value_step == 4'd0 && b == " ")) begin
                  if (value_step < 4'd7 && lb == hrp_pkg::ck_char(value_step)) begin
                    value_step_next = value_step + 4'd1;
                    if (value_step == 4'd6) begin
                      te_chunked_next = 1'b1;
                      value_step_next = hrp_pkg::VS_IDLE;
                    end
                  end else begin
                    value_step_next = hrp_pkg::VS_IDLE;
                  end
                end
              end
              // content-length
              if (cands[1]) begin
                len_mul = {4'd0, length_accum} * 36'd10 + {32'd0, d};
                if (line_pos < 5'd14) begin
                  if (lb != hrp_pkg::cl_char(line_pos)) cands_next[1] = 1'b0;
                end else if (line_pos == 5'd14) begin
                  if (b == ":" && !seen[1]) begin
                    seen_next[1] = 1'b1;
                    value_step_next = '0;
                    length_accum_next = '0;
                  end else begin
                    cands_next[1] = 1'b0;
                  end
                end else if (value_step == 4'd0 || value_step == 4'd2) begin
                  if (b == " " || b == 8'h09) begin
                    value_step_next = value_step;
                  end else if (value_step == 4'd0 && hrp_pkg::is_dig(b)) begin
                    length_accum_next = {28'd0, d};
                    value_step_next = 4'd1;
                  end else if (value_step == 4'd2 && b == 8'h0D) begin
                    value_step_next = 4'd3;
                  end else begin
                    value_step_next = hrp_pkg::VS_IDLE;
                  end
                end else if (value_step == 4'd1) begin
                  if (hrp_pkg::is_dig(b)) begin
                    if (len_mul[35:32] != 4'd0) value_step_next = hrp_pkg::VS_IDLE;
                    else length_accum_next = len_mul[31:0];
                  end else if (b == " " || b == 8'h09) value_step_next = 4'd2;
                  else if (b == 8'h0D) value_step_next = 4'd3;
                  else value_step_next = hrp_pkg::VS_IDLE;
                end else if (value_step != hrp_pkg::VS_IDLE) begin
                  if (b == 8'h0A) cl_ok_next = 1'b1;
                  value_step_next = hrp_pkg::VS_IDLE;
                end
              end
            end
            if (crlf) begin
              line_pos_next = '0;
              cands_next = 2'b11;
              value_step_next = '0;
            end else begin
              line_pos_next = (line_pos < 5'd31) ? line_pos + 5'd1 : 5'd31;
            end
          end

          // blank line ends the headers
          if (hdr_bytes_next >= 11'd4 && tail_window_next == 32'h0D0A0D0A) begin
            headers_seen_next = 1'b1;
            code_ok = (status_step_next == 4'd10 || status_step_next == hrp_pkg::ST_DONE)
              && status_accum_next <= 17'hFFFF;
            if (!code_ok) begin
              fin = 1'b1;
              fcode = hrp_pkg::OUT_PROTO;
            end else if (te_chunked_next) begin
              fin = 1'b1;
              fcode = hrp_pkg::OUT_CHUNKED;
            end else if (seen_next[1] && !cl_ok_next) begin
              fin = 1'b1;
              fcode = hrp_pkg::OUT_PROTO;
            end else begin
              if (seen_next[1]) length_valid_next = 1'b1;
              if (length_valid_next && length_accum_next == 32'd0) begin
                fin = 1'b1;
                fcode = hrp_pkg::OUT_OK;
              end else begin
                phase_next = hrp_pkg::PH_BODY;
              end
            end
          end
        end
      end else begin
        bv = 1'b1;
        keep = body_counter < {1'b0, capacity};
        if (body_counter != {33{1'b1}}) body_counter_next = body_counter + 33'd1;
        if (length_valid && body_counter_next >= {1'b0, length_accum}) end_close = 1'b1;
      end

      if (end_close) begin
        fin = 1'b1;
        if (length_valid && body_counter_next != {1'b0, length_accum})
          fcode = hrp_pkg::OUT_PROTO;
        else if (body_counter_next > {1'b0, capacity}) fcode = hrp_pkg::OUT_BODY_OVF;
        else fcode = hrp_pkg::OUT_OK;
      end
      if (fin) begin
        phase_next = hrp_pkg::PH_DONE;
        end_code_next = fcode;
      end
    end

    code_ok = (status_step_next == 4'd10 || status_step_next == hrp_pkg::ST_DONE)
      && status_accum_next <= 17'hFFFF;
    result.body_valid = bv;
    result.body_keep = keep;
    result.body_byte = bv ? b : 8'd0;
    result.headers_done = headers_seen_next;
    result.status_value = (headers_seen_next && code_ok) ? status_accum_next[15:0] : 16'd0;
    result.length_known = length_valid_next;
    result.declared_len = length_valid_next ? length_accum_next : 32'd0;
    result.body_total = body_counter_next[32] ? 32'hFFFF_FFFF : body_counter_next[31:0];
    result.finished = phase_next == hrp_pkg::PH_DONE;
    result.outcome = (phase_next == hrp_pkg::PH_DONE) ? end_code_next : hrp_pkg::OUT_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hrp_pkg::PH_HEAD;
      hdr_bytes <= '0;
      tail_window <= '0;
      status_step <= '0;
      status_accum <= '0;
      line_pos <= '0;
      cands <= 2'b11;
      value_step <= '0;
      seen <= '0;
      length_accum <= '0;
      length_valid <= 1'b0;
      body_counter <= '0;
      elapsed_ms <= '0;
      end_code <= '0;
      past_status <= 1'b0;
      search_stopped <= 1'b0;
      te_chunked <= 1'b0;
      cl_ok <= 1'b0;
      status_neg <= 1'b0;
      headers_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        phase <= phase_next;
        hdr_bytes <= hdr_bytes_next;
        tail_window <= tail_window_next;
        status_step <= status_step_next;
        status_accum <= status_accum_next;
        line_pos <= line_pos_next;
        cands <= cands_next;
        value_step <= value_step_next;
        seen <= seen_next;
        length_accum <= length_accum_next;
        length_valid <= length_valid_next;
        body_counter <= body_counter_next;
        elapsed_ms <= elapsed_ms_next;
        end_code <= end_code_next;
        past_status <= past_status_next;
        search_stopped <= search_stopped_next;
        te_chunked <= te_chunked_next;
        cl_ok <= cl_ok_next;
        status_neg <= status_neg_next;
        headers_seen <= headers_seen_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_item <= result;
  end

  `HRP_ASSERT(a_stall_blocks, out_valid && !out_ready |-> !in_ready, "input taken while stalled")
  `HRP_ASSERT(a_done_outcome, out_valid && !out_item.finished |-> out_item.outcome == hrp_pkg::OUT_OK, "outcome while running")
  `HRP_ASSERT(a_body_after_hdr, out_valid && out_item.body_valid |-> out_item.headers_done, "body before headers")
  `HRP_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result after reset")

endmodule

// File: bench/hrp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrp_checker
// Watches both item channels, predicts each result from the accepted input
// item and the register settings, and compares each result as a whole.
// ----------------------------------------------------------------------------
module hrp_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  hrp_pkg::in_item_t   in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  hrp_pkg::out_item_t  out_item,
  input  logic [31:0]         resp_timeout,
  input  logic [31:0]         capacity,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen
);

  hrp_pkg::out_item_t expected_q[$];

  // parser state
  logic [1:0]  ph;
  logic [31:0] hdr_cnt;
  logic [31:0] tail;
  logic [3:0]  sl_step;
  logic [31:0] code_acc;
  logic [4:0]  line_pos;
  logic [1:0]  cand;
  logic [3:0]  val_step;
  logic [1:0]  seen;
  logic [63:0] len_acc;
  logic        len_valid;
  logic [63:0] body_cnt;
  logic [31:0] elapsed;
  logic [2:0]  end_code;
  logic        past_status, search_stop, chunked, cl_ok, code_neg, hdr_seen;

  function automatic logic [7:0] lc(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic ws(input logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C || b == 8'h0D;
  endfunction

  function automatic logic dig(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic sgn(input logic [7:0] b);
    return b == "+" || b == "-";
  endfunction

  task automatic clear_parse();
    ph = hrp_pkg::PH_HEAD; hdr_cnt = 0; tail = 0; sl_step = 0; code_acc = 0; line_pos = 0;
    cand = 2'b11; val_step = 0; seen = 0; len_acc = 0; len_valid = 0; body_cnt = 0;
    elapsed = 0; end_code = 0; past_status = 0; search_stop = 0; chunked = 0;
    cl_ok = 0; code_neg = 0; hdr_seen = 0;
  endtask

  task automatic end_response(input logic [2:0] c);
    ph = hrp_pkg::PH_DONE;
    end_code = c;
  endtask

  task automatic add_code_digit(input logic [7:0] b);
    logic [31:0] v;
    if (code_neg) begin
      if (b != "0") code_acc = 65536;
    end else begin
      v = code_acc * 10 + (b - "0");
      code_acc = v > 65536 ? 65536 : v;
    end
  endtask

  function automatic logic [7:0] http_ch(input logic [3:0] i);
    string s;
    s = "HTTP/";
    return s[i];
  endfunction

  task automatic status_step(input logic [7:0] b);
    logic [3:0] s, n;
    s = sl_step;
    n = hrp_pkg::ST_FAIL;
    if (s <= 4) begin
      n = (b == http_ch(s)) ? s + 1 : hrp_pkg::ST_FAIL;
    end else if (s == 5 || s == 7) begin
      if (ws(b)) n = s;
      else if (sgn(b)) n = (s == 5) ? 4'd13 : 4'd14;
      else if (dig(b)) n = s + 1;
    end else if (s == 13 || s == 14) begin
      if (dig(b)) n = (s == 13) ? 4'd6 : 4'd8;
    end else if (s == 6) begin
      if (dig(b)) n = 6;
      else if (b == ".") n = 7;
    end else if (s == 8 || s == 9) begin
      if (s == 8 && dig(b)) n = 8;
      else if (ws(b)) n = 9;
      else if (sgn(b)) begin
        code_neg = (b == "-");
        n = 15;
      end else if (s == 9 && dig(b)) begin
        add_code_digit(b);
        n = 10;
      end
    end else if (s == 15) begin
      if (dig(b)) begin
        add_code_digit(b);
        n = 10;
      end
    end else if (s == 10) begin
      if (dig(b)) begin
        add_code_digit(b);
        n = 10;
      end else n = hrp_pkg::ST_DONE;
    end else begin
      n = s;
    end
    sl_step = n;
  endtask

  function automatic logic [7:0] ck_ch(input logic [3:0] i);
    string s;
    s = "chunked";
    return s[i];
  endfunction

  task automatic value_step(input int which, input logic [7:0] b);
    logic [3:0] s;
    logic [63:0] d;
    s = val_step;
    if (s == hrp_pkg::VS_IDLE) return;
    if (which == 0) begin
      if (s == 0 && b == " ") return;
      if (s < 7 && lc(b) == ck_ch(s)) begin
        val_step = s + 1;
        if (val_step == 7) begin
          chunked = 1;
          val_step = hrp_pkg::VS_IDLE;
        end
      end else val_step = hrp_pkg::VS_IDLE;
      return;
    end
    if (s == 0 || s == 2) begin
      if (b == " " || b == 8'h09) return;
      if (s == 0 && dig(b)) begin
        len_acc = b - "0";
        val_step = 1;
      end else if (s == 2 && b == 8'h0D) val_step = 3;
      else val_step = hrp_pkg::VS_IDLE;
    end else if (s == 1) begin
      if (dig(b)) begin
        d = b - "0";
        if (len_acc > (64'hFFFF_FFFF - d) / 10) val_step = hrp_pkg::VS_IDLE;
        else len_acc = len_acc * 10 + d;
      end else if (b == " " || b == 8'h09) val_step = 2;
      else if (b == 8'h0D) val_step = 3;
      else val_step = hrp_pkg::VS_IDLE;
    end else begin
      if (b == 8'h0A) cl_ok = 1;
      val_step = hrp_pkg::VS_IDLE;
    end
  endtask

  task automatic line_step(input logic [7:0] b, input logic [7:0] prev);
    logic crlf;
    logic [4:0] pos;
    int len;
    string nm;
    crlf = (prev == 8'h0D && b == 8'h0A);
    pos = line_pos;
    if (!past_status) begin
      if (crlf) begin
        past_status = 1; line_pos = 0; cand = 2'b11; val_step = 0;
      end
      return;
    end
    if (pos == 0 && b == 8'h0D) search_stop = 1;
    if (!search_stop) begin
      for (int c = 0; c < 2; c++) begin
        if (c == 0) nm = "transfer-encoding";
        else nm = "content-length";
        len = nm.len();
        if (!cand[c]) continue;
        if (pos < len) begin
          if (lc(b) != nm[pos]) cand[c] = 0;
        end else if (pos == len) begin
          if (b == ":" && !seen[c]) begin
            seen[c] = 1;
            val_step = 0;
            if (c == 1) len_acc = 0;
          end else cand[c] = 0;
        end else value_step(c, b);
      end
    end
    if (crlf) begin
      line_pos = 0; cand = 2'b11; val_step = 0;
    end else line_pos = pos < 31 ? pos + 1 : 31;
  endtask

  function automatic logic code_ok();
    return (sl_step == 10 || sl_step == hrp_pkg::ST_DONE) && code_acc <= 65535;
  endfunction

  task automatic close_response();
    if (len_valid && body_cnt != len_acc) end_response(hrp_pkg::OUT_PROTO);
    else if (body_cnt > {32'd0, capacity}) end_response(hrp_pkg::OUT_BODY_OVF);
    else end_response(hrp_pkg::OUT_OK);
  endtask

  task automatic headers_end();
    hdr_seen = 1;
    if (!code_ok()) begin
      end_response(hrp_pkg::OUT_PROTO);
      return;
    end
    if (chunked) begin
      end_response(hrp_pkg::OUT_CHUNKED);
      return;
    end
    if (seen[1]) begin
      if (!cl_ok) begin
        end_response(hrp_pkg::OUT_PROTO);
        return;
      end
      len_valid = 1;
    end
    if (len_valid && len_acc == 0) end_response(hrp_pkg::OUT_OK);
    else ph = hrp_pkg::PH_BODY;
  endtask

  task automatic predict_result(input hrp_pkg::in_item_t it, output hrp_pkg::out_item_t r);
    logic bv, keep;
    logic [7:0] b, prev;
    b = it.data_byte;
    bv = 0;
    keep = 0;
    if (it.opcode == hrp_pkg::OP_RESTART) begin
      clear_parse();
    end else if (ph != hrp_pkg::PH_DONE) begin
      if (it.opcode == hrp_pkg::OP_TICK) begin
        if (elapsed != 32'hFFFF_FFFF) elapsed++;
        if (elapsed >= resp_timeout) end_response(hrp_pkg::OUT_TIMEOUT);
      end else if (elapsed >= resp_timeout) begin
        end_response(hrp_pkg::OUT_TIMEOUT);
      end else if (it.opcode == hrp_pkg::OP_CLOSE) begin
        if (ph == hrp_pkg::PH_HEAD) end_response(hrp_pkg::OUT_PROTO);
        else close_response();
      end else if (ph == hrp_pkg::PH_HEAD) begin
        if (hdr_cnt + 1 >= hrp_pkg::HeaderMax) begin
          end_response(hrp_pkg::OUT_HDR_OVF);
        end else begin
          prev = tail[7:0];
          hdr_cnt++;
          tail = {tail[23:0], b};
          status_step(b);
          line_step(b, prev);
          if (hdr_cnt >= 4 && tail == 32'h0D0A0D0A) headers_end();
        end
      end else begin
        bv = 1;
        keep = body_cnt < {32'd0, capacity};
        if (body_cnt != '1) body_cnt++;
        if (len_valid && body_cnt >= len_acc) close_response();
      end
    end
    r.body_valid = bv;
    r.body_keep = keep;
    r.body_byte = bv ? b : 8'd0;
    r.headers_done = hdr_seen;
    r.status_value = (hdr_seen && code_ok()) ? code_acc[15:0] : 16'd0;
    r.length_known = len_valid;
    r.declared_len = len_valid ? len_acc[31:0] : 32'd0;
    r.body_total = body_cnt > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : body_cnt[31:0];
    r.finished = (ph == hrp_pkg::PH_DONE);
    r.outcome = (ph == hrp_pkg::PH_DONE) ? end_code : hrp_pkg::OUT_OK;
  endtask

  hrp_pkg::out_item_t want;
  hrp_pkg::out_item_t pred;

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      expected_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_item) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_result(in_item, pred);
        expected_q.push_back(pred);
      end
    end
    pending <= expected_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives response streams, events and register settings into the parser,
// with random idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  hrp_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 0;
  hrp_pkg::out_item_t out_item;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [31:0] resp_timeout = 15000;
  logic [31:0] capacity = 0;
  int fail_count, pending, results_seen;
  int send_idle = 0, recv_stall = 0;
  int cycles = 0, sent = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  http_response_header_parser u_top (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hrp_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .resp_timeout, .capacity, .fail_count, .pending, .results_seen
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= ($urandom_range(99) >= recv_stall);
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx[0], 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == hrp_pkg::REG_TIMEOUT) resp_timeout <= v;
    else capacity <= v;
  endtask

  // hold valid until the item is taken; drop it only while idling
  task automatic send(input logic [1:0] op, input logic [7:0] b);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_item <= '{opcode: op, data_byte: b};
    @(posedge clk iff in_ready);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(hrp_pkg::OP_BYTE, s[i]);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0 || in_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic string mixcase(input string s);
    for (int i = 0; i < s.len(); i++)
      if ($urandom_range(1) && s[i] >= "a" && s[i] <= "z") s[i] = 8'(s[i] - 8'd32);
    return s;
  endfunction

  // one response, well formed most of the time, with random body and events
  task automatic random_response();
    string h;
    int blen, kind;
    send(hrp_pkg::OP_RESTART, 8'($urandom));
    kind = $urandom_range(9);
    blen = $urandom_range(12);
    h = $sformatf("HTTP/1.%0d %0d OK\r\n", $urandom_range(1), $urandom_range(999));
    if (kind == 0) h = {h, mixcase("Transfer-Encoding"), ": ", mixcase("chunked"), "\r\n"};
    else if (kind < 6) h = {h, mixcase("content-length"), $sformatf(": %0d \r\n", blen)};
    else if (kind == 6) h = {h, "Content-Length: 99999999999\r\n"};
    else if (kind == 7) h = {h, "Content-Length: 1x\r\n"};
    h = {h, "X: y\r\n\r\n"};
    for (int i = 0; i < h.len(); i++) begin
      if ($urandom_range(30) == 0) send(hrp_pkg::OP_TICK, 8'($urandom));
      send(hrp_pkg::OP_BYTE, ($urandom_range(60) == 0) ? 8'($urandom) : h[i]);
    end
    for (int i = 0; i < blen + $urandom_range(2); i++) begin
      case ($urandom_range(20))
        0: send(hrp_pkg::OP_TICK, 8'($urandom));
        1: send(hrp_pkg::OP_CLOSE, 8'($urandom));
        default: send(hrp_pkg::OP_BYTE, 8'($urandom));
      endcase
    end
    if ($urandom_range(1)) send(hrp_pkg::OP_CLOSE, 0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    reg_write(hrp_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
    reg_write(hrp_pkg::REG_CAPACITY, 4);
    // directed: length body, overflow by close, chunked, bad code, signs
    send_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\n");
    send_text("abcdef");
    send(hrp_pkg::OP_RESTART, 8'hFF);
    send_text("HTTP/1.0  +404\r\n\r\n");
    for (int i = 0; i < 6; i++) send(hrp_pkg::OP_BYTE, i == 0 ? 8'h00 : 8'hFF);
    send(hrp_pkg::OP_CLOSE, 0);
    send(hrp_pkg::OP_RESTART, 0);
    send_text("HTTP/1.1 -0\r\nTRANSFER-ENCODING: ChUnKeD\r\n\r\n");
    send(hrp_pkg::OP_RESTART, 0);
    send_text("HTTP/1.1 65536\r\n\r\n");
    send(hrp_pkg::OP_RESTART, 0);
    send_text("HTTP/1.1 200\r\ncontent-length:\t0\t\r\n\r\n");
    send(hrp_pkg::OP_RESTART, 0);
    send_text("HTTP/1.1 200\r\nContent-Length: 4294967295\r\n\r\nz");
    send(hrp_pkg::OP_CLOSE, 0);
    send(hrp_pkg::OP_RESTART, 0);
    send(hrp_pkg::OP_CLOSE, 0);
    drain();
    reg_write(hrp_pkg::REG_TIMEOUT, 1);
    reg_write(hrp_pkg::REG_CAPACITY, 0);
    send(hrp_pkg::OP_RESTART, 0);
    send(hrp_pkg::OP_TICK, 0);
    send(hrp_pkg::OP_BYTE, "H");
    send(hrp_pkg::OP_RESTART, 0);
    send(hrp_pkg::OP_BYTE, "H");
    drain();
    // random phases over idling profiles and register settings
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 88; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 88; end
        default: begin send_idle = 28; recv_stall = 28; end
      endcase
      drain();
      reg_write(hrp_pkg::REG_TIMEOUT, p == 7 ? 32'd1 : 32'd3 + $urandom_range(60));
      reg_write(hrp_pkg::REG_CAPACITY, p == 5 ? 32'hFFFF_FFFF : $urandom_range(10));
      random_response();
      if (p == 2) drain();
    end
    drain();
    $display("items sent: %0d, results checked: %0d, several register settings", sent,
             results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
